FILE: rtl/pixel_memory_blitter_unit_macros.svh
// ----------------------------------------------------------------------------
// pixel memory blitter assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PIXEL_MEMORY_BLITTER_UNIT_MACROS_SVH
`define PIXEL_MEMORY_BLITTER_UNIT_MACROS_SVH

`ifndef SYNTH

`define PMB_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define PMB_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define PMB_ASSERT_IMPL(name, clk, rstn, ante, cons)

`define PMB_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/pmb_pkg.sv
// ----------------------------------------------------------------------------
// pixel memory blitter package
// request and response types and function codes
// ----------------------------------------------------------------------------
package pmb_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned DIM_IN_W = 11;
  localparam int unsigned OFS_W    = 10;
  localparam int unsigned STRIDE_W = 11;
  localparam int unsigned CNT_W    = 21;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE    = 3'd0,
    FUNC_READ     = 3'd1,
    FUNC_FILL     = 3'd2,
    FUNC_COPY     = 3'd3,
    FUNC_COPY_KEY = 3'd4
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [BASE_W-1:0]   addr;
    logic [BASE_W-1:0]   src_base;
    logic [PIX_W-1:0]    data;
    logic [DIM_IN_W-1:0] rect_width;
    logic [DIM_IN_W-1:0] rect_height;
    logic [OFS_W-1:0]    dst_x;
    logic [OFS_W-1:0]    dst_y;
    logic [OFS_W-1:0]    src_x;
    logic [OFS_W-1:0]    src_y;
    logic [STRIDE_W-1:0] dst_stride;
    logic [STRIDE_W-1:0] src_stride;
  } pmb_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic [CNT_W-1:0] written_count;
  } pmb_rsp_t;

endpackage

FILE: rtl/pixel_memory_blitter_unit.sv
// ----------------------------------------------------------------------------
// pixel memory blitter unit
// 2d blit engine over one 32-bit pixel memory: pixel write and read,
// rectangle fill, copy and colour-keyed copy
// ----------------------------------------------------------------------------
// One request at a time. A pixel write goes through ST_FINISH to the
// registered response, a pixel read through ST_RDWAIT and ST_FINISH. A
// rectangle request forms the row products on acceptance, adds the bases
// in ST_SETUP and walks the clamped rectangle in ST_RUN; copies retire the
// last read in ST_DRAIN, and the response is loaded from ST_FINISH. The
// pixel memory has one read and one write port with registered read data,
// which sets the rate of one pixel per cycle; a copy reads a pixel while
// the one before it is written, with forwarding when both hit the same
// word. The memory is not cleared at reset: a pixel read before it was ever
// written returns undefined data. A zero width or height writes nothing.
// ----------------------------------------------------------------------------
`include "pixel_memory_blitter_unit_macros.svh"

module pixel_memory_blitter_unit #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned MAX_DIM   = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pmb_pkg::pmb_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pmb_pkg::pmb_rsp_t out_rsp_o
);

  localparam int unsigned AW     = ADDR_BITS;
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned PROD_W = pmb_pkg::STRIDE_W + pmb_pkg::OFS_W;
  localparam int unsigned PIX_W  = pmb_pkg::PIX_W;
  localparam int unsigned CNT_W  = pmb_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  pmb_pkg::pmb_rsp_t out_rsp_q;
  logic              p_valid_q;
  logic              fwd_q;

  // latched request
  logic [pmb_pkg::FUNC_W-1:0]   func_q;
  logic [pmb_pkg::BASE_W-1:0]   addr_q;
  logic [pmb_pkg::BASE_W-1:0]   src_base_q;
  logic [PIX_W-1:0]             data_q;
  logic [DIM_W-1:0]             cmd_w_q;
  logic [DIM_W-1:0]             cmd_h_q;
  logic [pmb_pkg::OFS_W-1:0]    dst_x_q;
  logic [pmb_pkg::OFS_W-1:0]    src_x_q;
  logic [pmb_pkg::STRIDE_W-1:0] dst_stride_q;
  logic [pmb_pkg::STRIDE_W-1:0] src_stride_q;
  logic [PROD_W-1:0]            dprod_q;
  logic [PROD_W-1:0]            sprod_q;

  // walk state
  logic [DIM_W-1:0] col_q;
  logic [DIM_W-1:0] row_q;
  logic [AW-1:0]    dst_row_q;
  logic [AW-1:0]    src_row_q;
  logic [AW-1:0]    dst_addr_q;
  logic [AW-1:0]    src_addr_q;
  logic [AW-1:0]    p_dst_q;
  logic [PIX_W-1:0] fwd_data_q;
  logic [PIX_W-1:0] rd_res_q;
  logic [CNT_W-1:0] cnt_q;

  logic             accept;
  logic             is_copy;
  logic             is_fill;
  logic             key_skip;
  logic             last_col;
  logic             last_row;
  logic             out_free;
  logic             out_load;
  logic             rect_wr;
  logic [PIX_W-1:0] px;
  logic [AW-1:0]    dst_row_nxt;
  logic [AW-1:0]    src_row_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_copy    = (func_q == pmb_pkg::FUNC_COPY) || (func_q == pmb_pkg::FUNC_COPY_KEY);
  assign is_fill    = (func_q == pmb_pkg::FUNC_FILL);
  assign px         = fwd_q ? fwd_data_q : ram_rdata;
  assign key_skip   = (func_q == pmb_pkg::FUNC_COPY_KEY) && (px == '0);
  assign last_col   = (col_q == cmd_w_q - DIM_W'(1));
  assign last_row   = (row_q == cmd_h_q - DIM_W'(1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == ST_FINISH) && out_free;
  assign rect_wr    = ((state_q == ST_RUN) && is_fill) || (p_valid_q && !key_skip);
  assign dst_row_nxt = dst_row_q + AW'(dst_stride_q);
  assign src_row_nxt = src_row_q + AW'(src_stride_q);

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_dst_q;
    ram_wdata = px;
    if (accept && (in_req_i.func == pmb_pkg::FUNC_WRITE)) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(in_req_i.addr);
      ram_wdata = in_req_i.data;
    end else if ((state_q == ST_RUN) && is_fill) begin
      ram_we    = 1'b1;
      ram_waddr = dst_addr_q;
      ram_wdata = data_q;
    end else if (p_valid_q && !key_skip) begin
      ram_we    = 1'b1;
    end
    ram_raddr = accept ? AW'(in_req_i.addr) : src_addr_q;
  end

  pmb_ram #(
    .AW (AW),
    .DW (PIX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control and registered response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      p_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      p_valid_q <= (state_q == ST_RUN) && is_copy;
      fwd_q     <= ram_we && (ram_waddr == ram_raddr);
      if (out_load) begin
        out_valid_q             <= 1'b1;
        out_rsp_q.read_data     <= rd_res_q;
        out_rsp_q.written_count <= cnt_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_req_i.func)
              pmb_pkg::FUNC_READ:     state_q <= ST_RDWAIT;
              pmb_pkg::FUNC_FILL,
              pmb_pkg::FUNC_COPY,
              pmb_pkg::FUNC_COPY_KEY: state_q <= ST_SETUP;
              default:                state_q <= ST_FINISH;
            endcase
          end
        end
        ST_RDWAIT: begin
          state_q <= ST_FINISH;
        end
        ST_SETUP: begin
          if ((cmd_w_q == '0) || (cmd_h_q == '0)) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_col && last_row) begin
            state_q <= is_copy ? ST_DRAIN : ST_FINISH;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // request fields, address walk and counters
  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
    p_dst_q    <= dst_addr_q;
    if (accept) begin
      func_q       <= in_req_i.func;
      addr_q       <= in_req_i.addr;
      src_base_q   <= in_req_i.src_base;
      data_q       <= in_req_i.data;
      cmd_w_q      <= (32'(in_req_i.rect_width) > MAX_DIM) ?
                      DIM_W'(MAX_DIM) : DIM_W'(in_req_i.rect_width);
      cmd_h_q      <= (32'(in_req_i.rect_height) > MAX_DIM) ?
                      DIM_W'(MAX_DIM) : DIM_W'(in_req_i.rect_height);
      dst_x_q      <= in_req_i.dst_x;
      src_x_q      <= in_req_i.src_x;
      dst_stride_q <= in_req_i.dst_stride;
      src_stride_q <= in_req_i.src_stride;
      dprod_q      <= PROD_W'(in_req_i.dst_stride) * PROD_W'(in_req_i.dst_y);
      sprod_q      <= PROD_W'(in_req_i.src_stride) * PROD_W'(in_req_i.src_y);
      rd_res_q     <= '0;
      cnt_q        <= (in_req_i.func == pmb_pkg::FUNC_WRITE) ? CNT_W'(1) : '0;
    end else if (rect_wr) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (state_q == ST_RDWAIT) begin
      rd_res_q <= ram_rdata;
    end
    if (state_q == ST_SETUP) begin
      col_q      <= '0;
      row_q      <= '0;
      dst_row_q  <= AW'(addr_q) + AW'(dprod_q) + AW'(dst_x_q);
      dst_addr_q <= AW'(addr_q) + AW'(dprod_q) + AW'(dst_x_q);
      src_row_q  <= AW'(src_base_q) + AW'(sprod_q) + AW'(src_x_q);
      src_addr_q <= AW'(src_base_q) + AW'(sprod_q) + AW'(src_x_q);
    end else if (state_q == ST_RUN) begin
      if (last_col) begin
        col_q      <= '0;
        row_q      <= row_q + DIM_W'(1);
        dst_row_q  <= dst_row_nxt;
        dst_addr_q <= dst_row_nxt;
        src_row_q  <= src_row_nxt;
        src_addr_q <= src_row_nxt;
      end else begin
        col_q      <= col_q + DIM_W'(1);
        dst_addr_q <= dst_addr_q + AW'(1);
        src_addr_q <= src_addr_q + AW'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `PMB_ASSERT_IMPL(a_accept_pipe_empty, clk_i, rst_ni, accept, !p_valid_q)
  `PMB_ASSERT_IMPL(a_pipe_from_run, clk_i, rst_ni, p_valid_q, $past(state_q == ST_RUN))
  `PMB_ASSERT_IMPL(a_write_source, clk_i, rst_ni, ram_we && !accept,
                   (state_q == ST_RUN) || p_valid_q)
  `PMB_ASSERT_NEXT(a_finish_loads, clk_i, rst_ni, (state_q == ST_FINISH) && out_free,
                   out_valid_q && (state_q == ST_IDLE))

endmodule

FILE: rtl/pmb_ram.sv
// ----------------------------------------------------------------------------
// pixel memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pmb_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel memory blitter unit testbench
// drives pixel writes and reads, fills, plain and colour-keyed copies and
// unused function codes through the request channel. A pixel memory mirror
// in the testbench predicts each response, which is compared field by field.
// The memory is fully written early on, so no read ever hits an unwritten
// pixel.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ADDR_BITS       = 16;
  localparam int unsigned MAX_DIM         = 1024;
  localparam int unsigned WATCHDOG_LIMIT  = 300000;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned SETTLE_CYCLES   = 32;
  localparam logic [pmb_pkg::FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [pmb_pkg::FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  pmb_pkg::pmb_req_t in_req    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pmb_pkg::pmb_rsp_t out_rsp;

  logic [pmb_pkg::PIX_W-1:0] pixel_mirror [0:(1 << ADDR_BITS)-1];
  pmb_pkg::pmb_rsp_t         expected_rsp_q [$];
  int unsigned               error_count     = 0;
  int unsigned               ready_stall_pct = 0;
  int unsigned               hold_left       = 0;
  bit                        hold_request    = 1'b0;
  int unsigned               idle_cycles     = 0;

  pixel_memory_blitter_unit #(
    .ADDR_BITS(ADDR_BITS),
    .MAX_DIM  (MAX_DIM)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always #4 clk = ~clk;

  function automatic logic [ADDR_BITS-1:0] rect_addr(input int unsigned base,
                                                     input int unsigned stride,
                                                     input int unsigned x_ofs,
                                                     input int unsigned y_ofs,
                                                     input int unsigned col,
                                                     input int unsigned row);
    int unsigned sum;
    sum = base + stride * (y_ofs + row) + x_ofs + col;
    return sum[ADDR_BITS-1:0];
  endfunction

  function automatic pmb_pkg::pmb_rsp_t apply_blit(input pmb_pkg::pmb_req_t req);
    pmb_pkg::pmb_rsp_t         rsp;
    int unsigned               w, h, cnt;
    logic [ADDR_BITS-1:0]      src, dst;
    logic [pmb_pkg::PIX_W-1:0] px;
    rsp = '0;
    cnt = 0;
    w = (req.rect_width > MAX_DIM) ? MAX_DIM : req.rect_width;
    h = (req.rect_height > MAX_DIM) ? MAX_DIM : req.rect_height;
    case (req.func)
      pmb_pkg::FUNC_WRITE: begin
        pixel_mirror[req.addr] = req.data;
        cnt = 1;
      end
      pmb_pkg::FUNC_READ: begin
        rsp.read_data = pixel_mirror[req.addr];
      end
      pmb_pkg::FUNC_FILL: begin
        for (int unsigned r = 0; r < h; r++)
          for (int unsigned c = 0; c < w; c++) begin
            dst = rect_addr(req.addr, req.dst_stride, req.dst_x, req.dst_y, c, r);
            pixel_mirror[dst] = req.data;
            cnt++;
          end
      end
      pmb_pkg::FUNC_COPY, pmb_pkg::FUNC_COPY_KEY: begin
        for (int unsigned r = 0; r < h; r++)
          for (int unsigned c = 0; c < w; c++) begin
            src = rect_addr(req.src_base, req.src_stride, req.src_x, req.src_y, c, r);
            px  = pixel_mirror[src];
            if (req.func == pmb_pkg::FUNC_COPY || px != '0) begin
              dst = rect_addr(req.addr, req.dst_stride, req.dst_x, req.dst_y, c, r);
              pixel_mirror[dst] = px;
              cnt++;
            end
          end
      end
      default: ;
    endcase
    rsp.written_count = cnt[pmb_pkg::CNT_W-1:0];
    return rsp;
  endfunction

  function automatic pmb_pkg::pmb_req_t make_req(
      input logic [pmb_pkg::FUNC_W-1:0]   func,
      input logic [pmb_pkg::BASE_W-1:0]   addr,
      input logic [pmb_pkg::BASE_W-1:0]   src_base,
      input logic [pmb_pkg::PIX_W-1:0]    data,
      input logic [pmb_pkg::DIM_IN_W-1:0] w,
      input logic [pmb_pkg::DIM_IN_W-1:0] h,
      input logic [pmb_pkg::OFS_W-1:0]    dx,
      input logic [pmb_pkg::OFS_W-1:0]    dy,
      input logic [pmb_pkg::OFS_W-1:0]    sx,
      input logic [pmb_pkg::OFS_W-1:0]    sy,
      input logic [pmb_pkg::STRIDE_W-1:0] dst_stride,
      input logic [pmb_pkg::STRIDE_W-1:0] src_stride);
    pmb_pkg::pmb_req_t req;
    req.func        = func;
    req.addr        = addr;
    req.src_base    = src_base;
    req.data        = data;
    req.rect_width  = w;
    req.rect_height = h;
    req.dst_x       = dx;
    req.dst_y       = dy;
    req.src_x       = sx;
    req.src_y       = sy;
    req.dst_stride  = dst_stride;
    req.src_stride  = src_stride;
    return req;
  endfunction

  function automatic pmb_pkg::pmb_req_t random_request();
    pmb_pkg::pmb_req_t req;
    int unsigned       pick, big, narrow;
    req.addr        = pmb_pkg::BASE_W'($urandom());
    req.src_base    = pmb_pkg::BASE_W'($urandom());
    req.data        = ($urandom_range(3, 0) == 0) ? '0 : $urandom();
    req.dst_x       = pmb_pkg::OFS_W'($urandom());
    req.dst_y       = pmb_pkg::OFS_W'($urandom());
    req.src_x       = pmb_pkg::OFS_W'($urandom());
    req.src_y       = pmb_pkg::OFS_W'($urandom());
    req.dst_stride  = ($urandom_range(4, 0) == 0) ?
                      pmb_pkg::STRIDE_W'($urandom_range(2047, 0)) :
                      pmb_pkg::STRIDE_W'($urandom_range(1024, 1));
    req.src_stride  = ($urandom_range(4, 0) == 0) ?
                      pmb_pkg::STRIDE_W'($urandom_range(2047, 0)) :
                      pmb_pkg::STRIDE_W'($urandom_range(1024, 1));
    pick = $urandom_range(99, 0);
    if (pick < 6) begin
      big    = $urandom_range(2047, 0);
      narrow = $urandom_range(2, 0);
      if ($urandom_range(1, 0) == 0) begin
        req.rect_width  = pmb_pkg::DIM_IN_W'(big);
        req.rect_height = pmb_pkg::DIM_IN_W'(narrow);
      end else begin
        req.rect_width  = pmb_pkg::DIM_IN_W'(narrow);
        req.rect_height = pmb_pkg::DIM_IN_W'(big);
      end
    end else if (pick < 10) begin
      req.rect_width  = pmb_pkg::DIM_IN_W'($urandom_range(40, 0));
      req.rect_height = pmb_pkg::DIM_IN_W'($urandom_range(40, 0));
    end else begin
      req.rect_width  = pmb_pkg::DIM_IN_W'($urandom_range(12, 0));
      req.rect_height = pmb_pkg::DIM_IN_W'($urandom_range(12, 0));
    end
    pick = $urandom_range(99, 0);
    if (pick < 30)      req.func = pmb_pkg::FUNC_WRITE;
    else if (pick < 50) req.func = pmb_pkg::FUNC_READ;
    else if (pick < 68) req.func = pmb_pkg::FUNC_FILL;
    else if (pick < 83) req.func = pmb_pkg::FUNC_COPY;
    else if (pick < 96) req.func = pmb_pkg::FUNC_COPY_KEY;
    else req.func = pmb_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
    return req;
  endfunction

  task automatic send_request(input pmb_pkg::pmb_req_t req);
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_pixel_access();
    ready_stall_pct = 25;
    send_request(make_req(pmb_pkg::FUNC_WRITE, 16'h0000, '0, 32'hFFFF_FFFF,
                          0, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_req(pmb_pkg::FUNC_WRITE, 16'hFFFF, '1, 32'h0000_0000,
                          1, 1, 0, 0, 0, 0, 1, 1));
    send_request(make_req(pmb_pkg::FUNC_READ, 16'h0000, '0, '0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_req(pmb_pkg::FUNC_READ, 16'hFFFF, '0, '1, 0, 0, 0, 0, 0, 0, 1, 1));
  endtask

  task automatic test_full_fill();
    send_request(make_req(pmb_pkg::FUNC_FILL, 16'h0000, '0, 32'hC3A5_5A3C, 1024, 64,
                          0, 0, 0, 0, 1024, 1));
  endtask

  task automatic test_rectangles();
    // oversized width with wrapping offsets, oversized height on a zero stride
    send_request(make_req(pmb_pkg::FUNC_FILL, 16'hFFF0, '0, 32'h1234_5678, 2047, 1,
                          1023, 1023, 0, 0, 2047, 1));
    send_request(make_req(pmb_pkg::FUNC_FILL, 16'h4000, '0, 32'h8000_0001, 1, 2047,
                          5, 7, 0, 0, 0, 1));
    send_request(make_req(pmb_pkg::FUNC_FILL, 16'h3000, '0, 32'hDEAD_BEEF, 0, 5,
                          0, 0, 0, 0, 4, 1));
    send_request(make_req(pmb_pkg::FUNC_FILL, 16'h3000, '0, 32'hDEAD_BEEF, 5, 0,
                          0, 0, 0, 0, 4, 1));
    // colour key: a zero block holding one opaque pixel
    send_request(make_req(pmb_pkg::FUNC_FILL, 16'h0100, '0, 32'h0, 4, 3,
                          0, 0, 0, 0, 16, 1));
    send_request(make_req(pmb_pkg::FUNC_WRITE, 16'h0102, '0, 32'h0000_0001,
                          0, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_req(pmb_pkg::FUNC_COPY_KEY, 16'h0800, 16'h0100, '0, 4, 3,
                          0, 0, 0, 0, 0, 16));
    send_request(make_req(pmb_pkg::FUNC_COPY, 16'h0800, 16'h0100, '0, 4, 3,
                          0, 0, 0, 0, 64, 16));
    send_request(make_req(pmb_pkg::FUNC_COPY_KEY, 16'h0900, 16'h0110, '0, 4, 2,
                          0, 0, 0, 0, 64, 16));
    // overlapping copy smears the source to the right
    send_request(make_req(pmb_pkg::FUNC_COPY, 16'h0101, 16'h0100, '0, 8, 2,
                          0, 0, 0, 0, 16, 16));
    send_request(make_req(pmb_pkg::FUNC_READ, 16'h0108, '0, '0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_req(pmb_pkg::FUNC_COPY, 16'hFFFF, 16'hFFFE, '0, 5, 3,
                          1023, 1023, 1023, 1023, 1024, 2047));
    send_request(make_req(pmb_pkg::FUNC_READ, 16'h0802, '0, '0, 0, 0, 0, 0, 0, 0, 1, 1));
  endtask

  task automatic test_unknown_func();
    for (logic [pmb_pkg::FUNC_W:0] f = {1'b0, FUNC_UNUSED_FIRST};
         f <= {1'b0, FUNC_UNUSED_LAST}; f++)
      send_request(make_req(f[pmb_pkg::FUNC_W-1:0], 16'h0100, 16'h0200, 32'hFFFF_FFFF,
                            4, 4, 0, 0, 0, 0, 8, 8));
    send_request(make_req(pmb_pkg::FUNC_READ, 16'h0100, '0, '0, 0, 0, 0, 0, 0, 0, 1, 1));
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned max_gap,
                                     input int unsigned stall_pct);
    int unsigned burst;
    ready_stall_pct = stall_pct;
    burst = $urandom_range(16, 1);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(random_request());
      burst = burst - 1;
      if (burst == 0) begin
        burst = $urandom_range(16, 1);
        if (max_gap != 0) pause_sender($urandom_range(max_gap, 1));
      end
    end
  endtask

  task automatic test_backpressure();
    wait_all_results();
    ready_stall_pct = 0;
    hold_request    = 1'b1;
    for (int unsigned i = 0; i < 24; i++) begin
      send_request(random_request());
    end
    wait_all_results();
  endtask

  // response sink with random stalls and one long hold in the backpressure test
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_rsp_q.push_back(apply_blit(in_req));
  end

  always @(posedge clk) begin : check_responses
    pmb_pkg::pmb_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t ns unexpected response: expected none, actual %08h / %0d",
                 $time, out_rsp.read_data, out_rsp.written_count);
        error_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_rsp.read_data !== want.read_data) begin
          $display("%0t ns read_data mismatch: expected %08h, actual %08h",
                   $time, want.read_data, out_rsp.read_data);
          error_count++;
        end
        if (out_rsp.written_count !== want.written_count) begin
          $display("%0t ns written_count mismatch: expected %0d, actual %0d",
                   $time, want.written_count, out_rsp.written_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns watchdog expired with %0d responses outstanding",
                 $time, expected_rsp_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pixel_access();
    test_full_fill();
    test_rectangles();
    test_unknown_func();
    test_random_traffic(500, 0, 0);
    test_backpressure();
    test_random_traffic(700, 6, 30);
    wait_all_results();
    test_random_traffic(560, 12, 70);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
